@@ hdl/dllk_pkg.sv @@
// ----------------------------------------------------------------------------
// dllk_pkg
// Shared transaction types and command/status codes for the key list unit.
// ----------------------------------------------------------------------------
`default_nettype none
package dllk_pkg;

    localparam int unsigned KEY_W = 32;
    localparam int unsigned CMD_W = 3;
    localparam int unsigned STS_W = 2;
    localparam int unsigned CNT_W = 11;

    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DELKEY = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DELFST = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DELLST = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

    localparam logic [STS_W-1:0] STS_DONE  = 2'd0;
    localparam logic [STS_W-1:0] STS_FULL  = 2'd1;
    localparam logic [STS_W-1:0] STS_EMPTY = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        logic signed [KEY_W-1:0] key_in;
    } t_in_item;

    typedef struct packed {
        logic [STS_W-1:0]        status;
        logic signed [KEY_W-1:0] key_out;
        logic                    is_last;
        logic [CNT_W-1:0]        count;
    } t_out_item;

endpackage
`default_nettype wire

@@ hdl/dllk_ram.sv @@
// ----------------------------------------------------------------------------
// dllk_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module dllk_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ hdl/doubly_linked_key_list_unit.sv @@
// ----------------------------------------------------------------------------
// doubly_linked_key_list_unit
// Bounded doubly linked list of signed keys in node memory with a free list.
// ----------------------------------------------------------------------------
// Usage: each input transaction (cmd, key_in) yields exactly one output
// transaction (status, key_out, is_last, count). Commands: insert front,
// delete by key, delete first, delete last, read next.
// One command is in work at a time; o_in_stall is high while a command is
// in work or its result waits under i_out_stall.
// Path from the accepting edge to o_out_valid: unused codes, refused
// inserts and commands on an empty list go straight to OUT; read passes
// RD1, RD2, OUT; insert RD1, RD2, FIX, OUT; delete first/last RD1, RD2,
// UNL, FIX, OUT. Delete by key walks from the front until a node matches
// or all n nodes have been visited: each node visited costs a registered
// read of the node memories plus a compare. The next command is taken in
// the same cycle the result is taken.
// The result register holds while i_out_stall is high.
// Reset clears head, tail, free head, never-used mark and count, and sets reads back to the front.
// Node memories need no clearing: entries are read only after written.
// ----------------------------------------------------------------------------
`default_nettype none
module doubly_linked_key_list_unit #(
    parameter int unsigned CAPACITY = 1024
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire dllk_pkg::t_in_item  i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output dllk_pkg::t_out_item      o_out_data
);
    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_RD1  = 7'b0000010,
        S_RD2  = 7'b0000100,
        S_WALK = 7'b0001000,
        S_UNL  = 7'b0010000,
        S_FIX  = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state r_st, n_st;
    logic [dllk_pkg::CMD_W-1:0] r_cmd, n_cmd;
    logic [dllk_pkg::KEY_W-1:0] r_key, n_key;
    logic [AW-1:0] r_head, n_head, r_tail, n_tail, r_free, n_free;
    logic [CW-1:0] r_mark, n_mark, r_cnt, n_cnt, r_walk, n_walk;
    logic [AW-1:0] r_cur, n_cur;
    logic [AW-1:0] r_rcur, n_rcur;
    logic          r_front, n_front;
    logic [AW-1:0] r_nx, n_nx, r_pv, n_pv;
    dllk_pkg::t_out_item r_out, n_out;
    logic r_ov, n_ov;
    // old free head saved at unlink for the free-list link write
    logic [AW-1:0] r_nxfree;

    // memory ports
    logic          k_we, x_we, p_we;
    logic [AW-1:0] k_wa, x_wa, p_wa, rd_a;
    logic [dllk_pkg::KEY_W-1:0] k_wd, k_rd;
    logic [AW-1:0] x_wd, x_rd, p_wd, p_rd;

    dllk_ram #(.WIDTH(dllk_pkg::KEY_W), .DEPTH(CAPACITY)) u_keys (
        .i_clk(i_clk), .i_we(k_we), .i_waddr(k_wa), .i_wdata(k_wd),
        .i_raddr(rd_a), .o_rdata(k_rd));
    dllk_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_next (
        .i_clk(i_clk), .i_we(x_we), .i_waddr(x_wa), .i_wdata(x_wd),
        .i_raddr(rd_a), .o_rdata(x_rd));
    dllk_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_prev (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(p_wa), .i_wdata(p_wd),
        .i_raddr(rd_a), .o_rdata(p_rd));

    logic take, out_free;
    assign out_free   = !r_ov || !i_out_stall;
    assign o_in_stall = !((r_st == S_IDLE) && out_free);
    assign take       = i_in_valid && !o_in_stall;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    function automatic dllk_pkg::t_out_item mk(input logic [dllk_pkg::STS_W-1:0] s,
            input logic [dllk_pkg::KEY_W-1:0] k, input logic l, input logic [CW-1:0] c);
        dllk_pkg::t_out_item o;
        o.status  = s;
        o.key_out = k;
        o.is_last = l;
        o.count   = dllk_pkg::CNT_W'(c);
        return o;
    endfunction

    // sequencer: read, modify, write back
    always_comb begin
        n_st = r_st; n_cmd = r_cmd; n_key = r_key;
        n_head = r_head; n_tail = r_tail; n_free = r_free;
        n_mark = r_mark; n_cnt = r_cnt; n_walk = r_walk; n_cur = r_cur;
        n_rcur = r_rcur;
        n_front = r_front; n_nx = r_nx; n_pv = r_pv;
        n_out = r_out;
        n_ov = r_ov && i_out_stall;
        k_we = 1'b0; x_we = 1'b0; p_we = 1'b0;
        k_wa = r_cur; x_wa = r_cur; p_wa = r_cur;
        k_wd = r_key; x_wd = r_head; p_wd = r_pv;
        rd_a = r_cur;
        case (r_st)
            S_IDLE: begin
                if (take) begin
                    n_cmd = i_in_data.cmd;
                    n_key = i_in_data.key_in;
                    n_st  = S_OUT;
                    case (i_in_data.cmd)
                        dllk_pkg::CMD_INSERT: begin
                            if (r_cnt >= CW'(CAPACITY)) begin
                                n_out = mk(dllk_pkg::STS_FULL, '0, 1'b0, r_cnt);
                            end else begin
                                n_cur = r_free;
                                rd_a  = r_free;
                                n_st  = S_RD1;
                            end
                        end
                        dllk_pkg::CMD_DELKEY, dllk_pkg::CMD_DELFST,
                        dllk_pkg::CMD_DELLST, dllk_pkg::CMD_READ: begin
                            if (r_cnt == '0) begin
                                n_out = mk(dllk_pkg::STS_EMPTY, '0, 1'b0, r_cnt);
                            end else begin
                                if (i_in_data.cmd == dllk_pkg::CMD_DELLST) n_cur = r_tail;
                                else if (i_in_data.cmd == dllk_pkg::CMD_READ && !r_front)
                                    n_cur = r_rcur;
                                else n_cur = r_head;
                                rd_a   = n_cur;
                                n_walk = '0;
                                n_st   = S_RD1;
                            end
                        end
                        default: n_out = mk(dllk_pkg::STS_DONE, '0, 1'b0, r_cnt);
                    endcase
                end
            end
            S_RD1: begin
                n_st = S_RD2;
            end
            S_RD2: begin
                n_st = S_OUT;
                case (r_cmd)
                    dllk_pkg::CMD_INSERT: begin
                        if (r_mark > r_cnt) begin
                            n_cur  = r_free;
                            n_free = x_rd;
                        end else begin
                            n_cur  = AW'(r_mark);
                            n_mark = r_mark + 1'b1;
                        end
                        k_we = 1'b1; k_wa = n_cur; k_wd = r_key;
                        x_we = 1'b1; x_wa = n_cur; x_wd = r_head;
                        p_we = 1'b1; p_wa = n_cur; p_wd = '0;
                        n_st = S_FIX;
                    end
                    dllk_pkg::CMD_READ: begin
                        if (r_cur == r_tail) begin
                            n_out   = mk(dllk_pkg::STS_DONE, k_rd, 1'b1, r_cnt);
                            n_front = 1'b1;
                        end else begin
                            n_out   = mk(dllk_pkg::STS_DONE, k_rd, 1'b0, r_cnt);
                            n_front = 1'b0;
                            n_rcur  = x_rd;
                        end
                    end
                    dllk_pkg::CMD_DELKEY: begin
                        if (k_rd == r_key) begin
                            n_nx = x_rd; n_pv = p_rd; n_st = S_UNL;
                        end else if (r_walk + 1'b1 >= r_cnt) begin
                            n_out = mk(dllk_pkg::STS_EMPTY, '0, 1'b0, r_cnt);
                        end else begin
                            n_walk = r_walk + 1'b1;
                            n_cur  = x_rd;
                            rd_a   = x_rd;
                            n_st   = S_WALK;
                        end
                    end
                    default: begin
                        n_nx = x_rd; n_pv = p_rd; n_st = S_UNL;
                    end
                endcase
            end
            S_WALK: begin
                n_st = S_RD2;
            end
            S_UNL: begin
                // patch neighbours, push node on free list
                if (r_cur == r_head) n_head = r_nx;
                else begin x_we = 1'b1; x_wa = r_pv; x_wd = r_nx; end
                if (r_cur == r_tail) n_tail = r_pv;
                else begin p_we = 1'b1; p_wa = r_nx; p_wd = r_pv; end
                k_we = 1'b0;
                n_free  = r_cur;
                n_cnt   = r_cnt - 1'b1;
                n_front = 1'b1;
                if (n_cnt == '0) begin n_head = '0; n_tail = '0; end
                n_out = mk(dllk_pkg::STS_DONE, '0, 1'b0, n_cnt);
                n_st  = S_FIX;
            end
            S_FIX: begin
                // second write port use: free link or old head's prev
                if (r_cmd == dllk_pkg::CMD_INSERT) begin
                    if (r_cnt != '0) begin p_we = 1'b1; p_wa = r_head; p_wd = r_cur; end
                    else n_tail = r_cur;
                    n_head  = r_cur;
                    n_cnt   = r_cnt + 1'b1;
                    n_front = 1'b1;
                    n_out   = mk(dllk_pkg::STS_DONE, '0, 1'b0, n_cnt);
                end else begin
                    x_we = 1'b1; x_wa = r_cur; x_wd = r_nxfree;
                end
                n_st = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_ov = 1'b1;
                    n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_st == S_UNL) r_nxfree <= r_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_head <= '0; r_tail <= '0; r_free <= '0;
            r_mark <= '0; r_cnt <= '0; r_front <= 1'b1; r_ov <= 1'b0;
        end else begin
            r_st <= n_st; r_head <= n_head; r_tail <= n_tail; r_free <= n_free;
            r_mark <= n_mark; r_cnt <= n_cnt; r_front <= n_front; r_ov <= n_ov;
        end
        r_cmd <= n_cmd; r_key <= n_key; r_walk <= n_walk; r_cur <= n_cur;
        r_rcur <= n_rcur;
        r_nx <= n_nx; r_pv <= n_pv; r_out <= n_out;
    end
endmodule
`default_nettype wire

@@ hdl/dllk_checker.sv @@
// ----------------------------------------------------------------------------
// dllk_checker
// Port-level checks on the key list unit.
// ----------------------------------------------------------------------------
`default_nettype none
module dllk_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                o_in_stall,
    input wire logic                o_out_valid,
    input wire logic                i_out_stall,
    input wire dllk_pkg::t_out_item o_out_data
);
    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed under stall");
    // no result without a command first
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without command");
    // results report a key only on success
    a_sts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != dllk_pkg::STS_DONE |->
        o_out_data.key_out == '0 && !o_out_data.is_last)
        else $error("key on failing status");
    // count stays within 1024, the default capacity
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.count <= 11'd1024)
        else $error("count overflow");
endmodule

bind doubly_linked_key_list_unit dllk_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .o_in_stall(o_in_stall), .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall), .o_out_data(o_out_data));
`default_nettype wire
